/* hdl/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants
// Defaults, command codes, register indexes and controller command struct.
// ----------------------------------------------------------------------------
package gbn_pkg;
   localparam int WINDOW_MAX_DEF    = 8;
   localparam int BUFFER_SLOTS_DEF  = 16;
   localparam int PAYLOAD_WORDS_DEF = 5;
   localparam int SEQ_BITS_DEF      = 16;

   localparam logic [1:0] CMD_MSG  = 2'd0;
   localparam logic [1:0] CMD_ACK  = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   localparam logic [0:0] REG_WINDOW  = 1'd0;
   localparam logic [0:0] REG_TIMEOUT = 1'd1;

   localparam logic [3:0]  WINDOW_RESET  = 4'd8;
   localparam logic [15:0] TIMEOUT_RESET = 16'd25;

   // controller -> datapath
   typedef struct packed {
      logic absorb;     // take input word into assembly
      logic start_send; // begin sending admitted packets
      logic start_retx; // begin retransmission from base
      logic step;       // emitted a word; advance
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic busy_done;  // nothing more to emit in current burst
      logic item_done;  // absorbed word completed an item
      logic is_drop;    // completed message dropped
      logic last_word;  // word on show is the final word of the burst
   } dp_stat_type;
endpackage

/* hdl/gbn_if.sv */
// ----------------------------------------------------------------------------
// gbn_stream_if: valid/ready channel
// Generic payload channel with source and sink modports.
// ----------------------------------------------------------------------------
interface gbn_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/gbn_datapath.sv */
// ----------------------------------------------------------------------------
// gbn_datapath: ring store, sequence pointers, timer and word emitter
// Executes controller commands; emits one packet word per step.
// ----------------------------------------------------------------------------
module gbn_datapath import gbn_pkg::*; #(
   parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
   parameter int BUFFER_SLOTS  = BUFFER_SLOTS_DEF,
   parameter int PAYLOAD_WORDS = PAYLOAD_WORDS_DEF,
   parameter int SEQ_BITS      = SEQ_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [15:0]        csr_write_data,
   input  logic [1:0]         in_cmd,
   input  logic [31:0]        in_word,
   input  logic               in_last,
   input  logic [15:0]        in_ack_seq,
   input  logic [15:0]        in_ack_num,
   input  logic [31:0]        in_ack_checksum,
   input  ctl_cmd_type        ctl,
   output dp_stat_type        stat,
   output logic               o_kind,
   output logic [15:0]        o_seq,
   output logic [2:0]         o_index,
   output logic [31:0]        o_word,
   output logic [31:0]        o_checksum,
   output logic               o_pend
);
   localparam int SLOT_W = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
   localparam int WI_W   = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
   localparam int ADDR_W = $clog2(BUFFER_SLOTS * PAYLOAD_WORDS);
   localparam int SUM_W  = SEQ_BITS + SLOT_W + 1;
   localparam logic [SEQ_BITS-1:0] SEQ_ONES = '1;
   localparam logic [SEQ_BITS:0] CAP =
      (BUFFER_SLOTS > (2.0**SEQ_BITS) - 1) ? {1'b0, SEQ_ONES}
                                          : (SEQ_BITS+1)'(BUFFER_SLOTS);
   localparam logic [WI_W-1:0] LAST_WI = WI_W'(PAYLOAD_WORDS - 1);
   localparam logic [SEQ_BITS-1:0] SEQ_ONE = SEQ_BITS'(1);

   logic [31:0] mem [BUFFER_SLOTS*PAYLOAD_WORDS];
   logic [12:0] sums [BUFFER_SLOTS];
   logic [WI_W-1:0] lens [BUFFER_SLOTS];   // last written word of each slot

   logic [3:0]  win_reg_ff;
   logic [15:0] tmo_reg_ff;
   logic [SEQ_BITS-1:0] base_ff, nts_ff, nta_ff, cur_ff;
   logic [SLOT_W-1:0] head_ff;
   logic [15:0] tcount_ff;
   logic        trun_ff;
   logic [WI_W-1:0] wcount_ff, widx_ff;
   logic [12:0] acc_ff;
   logic [1:0]  kind_ff;
   logic        retx_ff;
   logic        drop_ff;
   logic        item_done_ff;

   // effective window
   logic [3:0] win;
   always_comb begin
      win = win_reg_ff;
      if (win == 4'd0) win = 4'd1;
      if (32'(win) > WINDOW_MAX) win = 4'(WINDOW_MAX);
   end

   // offsets never exceed the ring length, so one conditional subtract wraps
   function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] h,
                                                 input logic [SEQ_BITS-1:0] d);
      logic [SUM_W-1:0] t;
      t = SUM_W'(h) + SUM_W'(d);
      if (t >= SUM_W'(BUFFER_SLOTS)) t = t - SUM_W'(BUFFER_SLOTS);
      return SLOT_W'(t);
   endfunction

   logic [SEQ_BITS-1:0] dist_nta, dist_nts, dist_cur, dist_ack;
   assign dist_nta = nta_ff - base_ff;
   assign dist_nts = nts_ff - base_ff;
   assign dist_cur = cur_ff - base_ff;
   logic full;
   assign full = {1'b0, dist_nta} >= CAP;
   logic [SLOT_W-1:0] wslot, cslot;
   assign wslot = slot_at(head_ff, dist_nta);
   assign cslot = slot_at(head_ff, dist_cur);

   // word assembly
   logic [1:0] eff_kind;
   logic       fresh;
   logic [12:0] acc_next;
   logic [WI_W-1:0] wpos;
   logic completes;
   always_comb begin
      fresh    = (wcount_ff == '0) || (kind_ff != in_cmd);
      wpos     = fresh ? '0 : wcount_ff;
      eff_kind = in_cmd;
      acc_next = (fresh ? 13'd0 : acc_ff) + 13'(in_word[7:0]) + 13'(in_word[15:8])
               + 13'(in_word[23:16]) + 13'(in_word[31:24]);
      completes = in_last || (wpos == LAST_WI);
   end

   logic [31:0] ack_cs;
   assign ack_cs = 32'(acc_next) + 32'(in_ack_seq) + 32'(in_ack_num);
   logic [SEQ_BITS-1:0] ack_a;
   assign ack_a = SEQ_BITS'(in_ack_num);
   assign dist_ack = ack_a - base_ff;
   logic ack_ok;
   assign ack_ok = (ack_cs == in_ack_checksum) && (dist_ack < dist_nts);

   // burst bookkeeping: packet at the pointer now, and one after it
   logic can_send;
   assign can_send = (dist_nts < SEQ_BITS'(win)) && (nts_ff != nta_ff);
   logic can_send_after;
   assign can_send_after = (({1'b0, dist_nts} + (SEQ_BITS+1)'(1)) < (SEQ_BITS+1)'(win))
                        && ((nts_ff + SEQ_ONE) != nta_ff);
   logic burst_more, after_more;
   always_comb begin
      if (retx_ff) begin
         burst_more = (cur_ff != nts_ff);
         after_more = ((cur_ff + SEQ_ONE) != nts_ff);
      end else begin
         burst_more = can_send;
         after_more = can_send_after;
      end
   end

   // store write address and data
   logic        mwe;
   logic [ADDR_W-1:0] maddr;
   logic [31:0] mdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_reg_ff <= WINDOW_RESET;
         tmo_reg_ff <= TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == REG_WINDOW) win_reg_ff <= csr_write_data[3:0];
         else                         tmo_reg_ff <= csr_write_data;
      end
   end

   logic tick_fire;
   logic [15:0] tmo;
   assign tmo = (tmo_reg_ff == 16'd0) ? 16'd1 : tmo_reg_ff;
   assign tick_fire = trun_ff && ((tcount_ff + 16'd1) >= tmo);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= SEQ_ONE;
         nts_ff    <= SEQ_ONE;
         nta_ff    <= SEQ_ONE;
         cur_ff    <= SEQ_ONE;
         head_ff   <= '0;
         tcount_ff <= '0;
         trun_ff   <= 1'b0;
         wcount_ff <= '0;
         widx_ff   <= '0;
         acc_ff    <= '0;
         kind_ff   <= CMD_MSG;
         retx_ff   <= 1'b0;
         drop_ff   <= 1'b0;
         item_done_ff <= 1'b0;
      end else begin
         item_done_ff <= 1'b0;
         if (ctl.absorb) begin
            drop_ff <= 1'b0;
            if (in_cmd == CMD_TICK) begin
               if (trun_ff) begin
                  if (tick_fire) begin
                     tcount_ff <= '0;
                     retx_ff <= 1'b1;
                     cur_ff <= base_ff;
                     item_done_ff <= 1'b1;
                  end else tcount_ff <= tcount_ff + 16'd1;
               end
            end else if (in_cmd == CMD_MSG || in_cmd == CMD_ACK) begin
               kind_ff <= eff_kind;
               acc_ff  <= acc_next;
               if (!completes) wcount_ff <= wpos + 1'b1;
               else begin
                  wcount_ff <= '0;
                  if (in_cmd == CMD_MSG) begin
                     if (full) begin
                        drop_ff <= 1'b1;
                        item_done_ff <= 1'b1;
                     end else begin
                        nta_ff  <= nta_ff + SEQ_ONE;
                        retx_ff <= 1'b0;
                        item_done_ff <= 1'b1;
                     end
                  end else if (ack_ok) begin
                     base_ff <= base_ff + dist_ack + SEQ_ONE;
                     head_ff <= slot_at(head_ff, dist_ack + SEQ_ONE);
                     tcount_ff <= '0;
                     trun_ff <= (base_ff + dist_ack + SEQ_ONE) != nts_ff;
                     retx_ff <= 1'b0;
                     item_done_ff <= 1'b1;
                  end
               end
            end
         end
         if (ctl.start_send || ctl.start_retx) widx_ff <= '0;
         if (ctl.start_send && !retx_ff) cur_ff <= nts_ff;
         if (ctl.step) begin
            if (widx_ff == LAST_WI) begin
               widx_ff <= '0;
               cur_ff <= cur_ff + SEQ_ONE;
               if (!retx_ff) begin
                  nts_ff <= nts_ff + SEQ_ONE;
                  if (!trun_ff) begin
                     trun_ff <= 1'b1;
                     tcount_ff <= '0;
                  end
               end
            end else widx_ff <= widx_ff + 1'b1;
         end
      end
   end

   // store writes: incoming message word
   always_comb begin
      mwe   = 1'b0;
      maddr = '0;
      mdata = '0;
      if (ctl.absorb && in_cmd == CMD_MSG && !full) begin
         mwe   = 1'b1;
         maddr = ADDR_W'(32'(wslot) * PAYLOAD_WORDS + 32'(wpos));
         mdata = in_word;
      end
   end

   // short messages: words past the recorded last one read as zero
   always_ff @(posedge clock) begin
      if (mwe) mem[maddr] <= mdata;
      if (ctl.absorb && in_cmd == CMD_MSG && !full && completes) begin
         sums[wslot] <= acc_next;
         lens[wslot] <= wpos;
      end
   end

   // output words registered from store
   logic [31:0] rd_word_ff;
   logic [12:0] rd_sum_ff;
   logic        rd_zero_ff;
   always_ff @(posedge clock) begin
      rd_word_ff <= mem[ADDR_W'(32'(cslot) * PAYLOAD_WORDS + 32'(widx_ff))];
      rd_sum_ff  <= sums[cslot];
      rd_zero_ff <= widx_ff > lens[cslot];
   end

   logic [SEQ_BITS-1:0] rd_seq_ff;
   logic [WI_W-1:0] rd_idx_ff;
   always_ff @(posedge clock) begin
      rd_seq_ff <= cur_ff;
      rd_idx_ff <= widx_ff;
   end

   assign stat.busy_done = !burst_more;
   assign stat.item_done = item_done_ff;
   assign stat.is_drop   = drop_ff;
   assign stat.last_word = (widx_ff == LAST_WI) && !after_more;
   assign o_kind     = drop_ff;
   assign o_seq      = drop_ff ? 16'd0 : 16'(rd_seq_ff);
   assign o_index    = drop_ff ? 3'd0 : 3'(rd_idx_ff);
   assign o_word     = (drop_ff || rd_zero_ff) ? 32'd0 : rd_word_ff;
   assign o_checksum = drop_ff ? 32'd0 : 32'(rd_sum_ff) + 32'(rd_seq_ff) - 32'd1;
   assign o_pend     = !drop_ff && (rd_idx_ff == LAST_WI);
endmodule

/* hdl/gbn_controller.sv */
// ----------------------------------------------------------------------------
// gbn_controller: sequencer for accept, read, present and step
// One word is read, presented and handed off per loop.
// ----------------------------------------------------------------------------
module gbn_controller import gbn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   output logic        out_valid,
   input  logic        out_ready,
   output logic        out_run_end,
   output ctl_cmd_type ctl,
   input  dp_stat_type stat
);
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EVAL  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_SHOW  = 5'b01000,
      ST_DROP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic more;
   assign more = !stat.busy_done;

   always_comb begin
      state_in    = state_ff;
      in_ready    = 1'b0;
      out_valid   = 1'b0;
      out_run_end = 1'b0;
      ctl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready  = 1'b1;
            ctl.absorb = in_valid;
            if (in_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (stat.is_drop) state_in = ST_DROP;
            else if (stat.item_done && more) begin
               ctl.start_send = 1'b1;
               state_in = ST_READ;
            end else state_in = ST_IDLE;
         end
         ST_READ: state_in = ST_SHOW;
         ST_SHOW: begin
            out_valid = 1'b1;
            // last word of burst when this packet ends and nothing follows
            out_run_end = stat.last_word;
            if (out_ready) begin
               ctl.step = 1'b1;
               if (stat.last_word) state_in = ST_IDLE;
               else                state_in = ST_READ;
            end
         end
         ST_DROP: begin
            out_valid = 1'b1;
            out_run_end = 1'b1;
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(in_ready && out_valid)) else $error("ready and valid together");
   a_drop_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DROP |-> out_run_end) else $error("drop without run end");
   a_eval_after: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> state_ff == ST_EVAL) else $error("no eval");
endmodule

/* hdl/go_back_n_sender_unit.sv */
// ----------------------------------------------------------------------------
// go_back_n_sender_unit: Go-Back-N ARQ sender
// Assembles messages and acks, sends windowed packets, retransmits on timeout.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: one transaction per message word, ack word or timer tick.
//  rsp channel: one transaction per packet word sent, or one drop flag.
//  csr port: index 0 window size, index 1 timeout ticks; write while idle.
//  Each req transaction is evaluated after it is taken, before req is ready again.
//  Each result word is read from the store, then presented; a burst runs
//  until the window or outstanding list is exhausted.
//  While a burst runs req is not ready; a stalled rsp holds its word.
//  Reset: sequence pointers at one, timer stopped, window 8, timeout 25.
//  Store contents are undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
module go_back_n_sender_unit import gbn_pkg::*; #(
   parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
   parameter int BUFFER_SLOTS  = BUFFER_SLOTS_DEF,
   parameter int PAYLOAD_WORDS = PAYLOAD_WORDS_DEF,
   parameter int SEQ_BITS      = SEQ_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_payload_word,
   input  logic        req_word_last,
   input  logic [15:0] req_ack_seq,
   input  logic [15:0] req_ack_num,
   input  logic [31:0] req_ack_checksum,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [15:0] rsp_seq_num,
   output logic [2:0]  rsp_word_index,
   output logic [31:0] rsp_out_word,
   output logic [31:0] rsp_packet_checksum,
   output logic        rsp_packet_end,
   output logic        rsp_run_end
);
   ctl_cmd_type ctl;
   dp_stat_type stat;
   logic pend;

   gbn_datapath #(
      .WINDOW_MAX(WINDOW_MAX), .BUFFER_SLOTS(BUFFER_SLOTS),
      .PAYLOAD_WORDS(PAYLOAD_WORDS), .SEQ_BITS(SEQ_BITS)
   ) u_dp (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data,
      .in_cmd(req_cmd), .in_word(req_payload_word), .in_last(req_word_last),
      .in_ack_seq(req_ack_seq), .in_ack_num(req_ack_num),
      .in_ack_checksum(req_ack_checksum), .ctl, .stat,
      .o_kind(rsp_kind), .o_seq(rsp_seq_num), .o_index(rsp_word_index),
      .o_word(rsp_out_word), .o_checksum(rsp_packet_checksum), .o_pend(pend)
   );

   logic run_end_c;
   gbn_controller u_ctl (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_run_end(run_end_c),
      .ctl, .stat
   );

   // run ends on the final word of the final packet of the burst, or on a drop flag
   assign rsp_packet_end = pend;
   assign rsp_run_end = rsp_kind ? 1'b1 : (run_end_c && pend);
endmodule

/* sim/go_back_n_sender_unit_test.sv */
// ----------------------------------------------------------------------------
// go_back_n_sender_unit_test: self-checking bench for the Go-Back-N sender
// Drives message, ack and tick transactions with random bursts and gaps, keeps
// a model of the sender state, and compares every response word in order.
// ----------------------------------------------------------------------------
module go_back_n_sender_unit_test;
   import gbn_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_IDLE = 2'd3;   // ignored command code
   localparam int         NSLOT    = BUFFER_SLOTS_DEF;
   localparam int         NWORD    = PAYLOAD_WORDS_DEF;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] payload_word;
      logic        word_last;
      logic [15:0] ack_seq;
      logic [15:0] ack_num;
      logic [31:0] ack_checksum;
   } req_word_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] seq_num;
      logic [2:0]  word_index;
      logic [31:0] out_word;
      logic [31:0] packet_checksum;
      logic        packet_end;
      logic        run_end;
   } rsp_word_type;

   // Sender model plus queue of expected response words
   class packet_scoreboard;
      bit [31:0]  store [NSLOT][NWORD];
      bit [12:0]  slot_sum [NSLOT];
      bit [15:0]  base, nts, nta, tcount;
      bit         trun;
      int         wcount;
      bit [12:0]  accum;
      bit [1:0]   kind;
      int         head;
      bit [3:0]   win_reg;
      bit [15:0]  tmo_reg;
      rsp_word_type expected[$];
      int         errors;

      function new();
         base = 1; nts = 1; nta = 1; tcount = 0; trun = 0;
         wcount = 0; accum = 0; kind = CMD_MSG; head = 0;
         win_reg = WINDOW_RESET; tmo_reg = TIMEOUT_RESET; errors = 0;
      endfunction

      // append one expected response word
      function void add_word(rsp_word_type r);
         expected.insert(expected.size(), r);
      endfunction

      function void write_reg(logic idx, bit [15:0] data);
         if (idx == REG_WINDOW) win_reg = data[3:0];
         else tmo_reg = data;
      endfunction

      function int win_eff();
         if (win_reg < 1) return 1;
         if (win_reg > WINDOW_MAX_DEF) return WINDOW_MAX_DEF;
         return win_reg;
      endfunction

      function int slot_of(bit [15:0] seq);
         bit [15:0] d;
         d = seq - base;
         return (head + d) % NSLOT;
      endfunction

      function void send_packet(bit [15:0] seq);
         int s;
         rsp_word_type r;
         s = slot_of(seq);
         for (int i = 0; i < NWORD; i++) begin
            r.kind = 1'b0; r.seq_num = seq; r.word_index = 3'(i);
            r.out_word = store[s][i];
            r.packet_checksum = 32'(slot_sum[s]) + 32'(seq) - 32'd1;
            r.packet_end = (i == NWORD - 1); r.run_end = 1'b0;
            add_word(r);
         end
      endfunction

      function void send_admitted();
         bit [15:0] d;
         d = nts - base;
         while (d < win_eff() && nts != nta) begin
            send_packet(nts);
            nts++;
            d = nts - base;
         end
      endfunction

      // note an accepted request transaction
      function void accept(req_word_type q);
         int n0, ws;
         bit full;
         bit [15:0] d, dout, tmo;
         bit [31:0] cs;
         rsp_word_type drop;
         n0 = expected.size();
         if (q.cmd == CMD_IDLE) return;
         if (q.cmd == CMD_TICK) begin
            tmo = (tmo_reg == 0) ? 16'd1 : tmo_reg;
            if (trun) begin
               tcount++;
               if (tcount >= tmo) begin
                  tcount = 0;
                  for (bit [15:0] s = base; s != nts; s++) send_packet(s);
               end
            end
         end else begin
            d = nta - base;
            full = (d >= NSLOT);
            ws = slot_of(nta);
            if (wcount > 0 && kind != q.cmd) wcount = 0;
            if (wcount == 0) begin
               accum = 0;
               kind = q.cmd;
               if (q.cmd == CMD_MSG && !full)
                  for (int i = 0; i < NWORD; i++) store[ws][i] = 0;
            end
            for (int b = 0; b < 4; b++) accum += q.payload_word[8*b +: 8];
            if (q.cmd == CMD_MSG && !full) store[ws][wcount] = q.payload_word;
            if (!q.word_last && wcount + 1 < NWORD) begin
               wcount++;
               return;
            end
            wcount = 0;
            if (q.cmd == CMD_MSG) begin
               if (full) begin
                  drop = '0; drop.kind = 1'b1; drop.run_end = 1'b1;
                  add_word(drop);
                  return;
               end
               slot_sum[ws] = accum;
               nta++;
               send_admitted();
               if (expected.size() > n0 && !trun) begin
                  trun = 1; tcount = 0;
               end
            end else begin
               cs = 32'(accum) + 32'(q.ack_seq) + 32'(q.ack_num);
               d = q.ack_num - base;
               dout = nts - base;
               if (cs == q.ack_checksum && d < dout) begin
                  base = base + d + 16'd1;
                  head = (head + d + 1) % NSLOT;
                  send_admitted();
                  tcount = 0;
                  trun = (base != nts);
               end
            end
         end
         if (expected.size() > n0) expected[expected.size()-1].run_end = 1;
      endfunction

      // compare one response word against the oldest expectation
      function void check(rsp_word_type a);
         rsp_word_type e;
         if (expected.size() == 0) begin
            $error("unexpected response: %p", a);
            errors++;
            return;
         end
         e = expected.pop_front();
         if (a.kind != e.kind) begin
            $error("kind exp %0d got %0d", e.kind, a.kind); errors++;
         end
         if (a.seq_num != e.seq_num) begin
            $error("seq_num exp %0d got %0d", e.seq_num, a.seq_num); errors++;
         end
         if (a.word_index != e.word_index) begin
            $error("word_index exp %0d got %0d", e.word_index, a.word_index); errors++;
         end
         if (a.out_word != e.out_word) begin
            $error("out_word exp %h got %h", e.out_word, a.out_word); errors++;
         end
         if (a.packet_checksum != e.packet_checksum) begin
            $error("packet_checksum exp %h got %h", e.packet_checksum,
                   a.packet_checksum);
            errors++;
         end
         if (a.packet_end != e.packet_end) begin
            $error("packet_end exp %0d got %0d", e.packet_end, a.packet_end); errors++;
         end
         if (a.run_end != e.run_end) begin
            $error("run_end exp %0d got %0d", e.run_end, a.run_end); errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_enable = 0;
   logic        csr_index = 0;
   logic [15:0] csr_write_data = 0;
   logic        rsp_hold = 0;      // long receiver hold-off
   int          items_sent = 0;
   int          burst_left = 0;

   packet_scoreboard sb = new();

   gbn_stream_if #(.payload_type(req_word_type)) req_ch ();
   gbn_stream_if #(.payload_type(rsp_word_type)) rsp_ch ();

   initial begin
      req_ch.valid = 0;
      req_ch.payload = '0;
      rsp_ch.ready = 0;
   end

   go_back_n_sender_unit dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_ch.valid),
      .req_ready           (req_ch.ready),
      .req_cmd             (req_ch.payload.cmd),
      .req_payload_word    (req_ch.payload.payload_word),
      .req_word_last       (req_ch.payload.word_last),
      .req_ack_seq         (req_ch.payload.ack_seq),
      .req_ack_num         (req_ch.payload.ack_num),
      .req_ack_checksum    (req_ch.payload.ack_checksum),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_kind            (rsp_ch.payload.kind),
      .rsp_seq_num         (rsp_ch.payload.seq_num),
      .rsp_word_index      (rsp_ch.payload.word_index),
      .rsp_out_word        (rsp_ch.payload.out_word),
      .rsp_packet_checksum (rsp_ch.payload.packet_checksum),
      .rsp_packet_end      (rsp_ch.payload.packet_end),
      .rsp_run_end         (rsp_ch.payload.run_end)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Safety net: worst case is far below this
   initial begin
      #1000000;
      $display("Simulation FAILED");
      $finish;
   end

   // Receiver: random short stalls, calm stretches, plus the long hold-off
   initial begin : receiver
      int stall_left;
      int cyc;
      stall_left = 0;
      cyc = 0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) sb.check(rsp_ch.payload);
         cyc++;
         if (stall_left > 0) stall_left--;
         else if ((cyc / 300) % 3 != 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
         rsp_ch.ready <= !reset && !rsp_hold && stall_left == 0;
      end
   end

   // Long hold-off so the response side backs up and req stalls
   initial begin : hold_off
      wait (items_sent >= 70);
      @(posedge clock);
      rsp_hold <= 1;
      repeat (400) @(posedge clock);
      rsp_hold <= 0;
   end

   // Push one request transaction; valid stays up inside a burst
   task automatic push(req_word_type q);
      int gap;
      req_ch.valid <= 1;
      req_ch.payload <= q;
      do @(posedge clock); while (!req_ch.ready);
      sb.accept(q);
      items_sent++;
      if (burst_left > 0) burst_left--;
      else begin
         req_ch.valid <= 0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(0, 15);
      end
   endtask

   function automatic req_word_type blank(logic [1:0] cmd);
      req_word_type q;
      q.cmd = cmd;
      q.payload_word = $urandom;
      q.word_last = 1'($urandom_range(0, 1));
      q.ack_seq = 16'($urandom);
      q.ack_num = 16'($urandom);
      q.ack_checksum = $urandom;
      return q;
   endfunction

   // Message of nw words; early word_last gives a short message
   task automatic send_msg(int nw, bit random_data, logic [31:0] fill);
      req_word_type q;
      for (int i = 0; i < nw; i++) begin
         q = blank(CMD_MSG);
         q.payload_word = random_data ? $urandom : fill;
         q.word_last = (i == nw - 1);
         push(q);
      end
   endtask

   // Ack of nw words; good selects a correct checksum
   task automatic send_ack(int nw, logic [15:0] num, bit good);
      req_word_type q;
      bit [12:0] acc;
      for (int i = 0; i < nw; i++) begin
         q = blank(CMD_ACK);
         q.word_last = (i == nw - 1);
         q.ack_num = num;
         if (q.word_last && good) begin
            acc = (sb.wcount > 0 && sb.kind == CMD_ACK) ? sb.accum : 13'd0;
            for (int b = 0; b < 4; b++) acc += q.payload_word[8*b +: 8];
            q.ack_checksum = 32'(acc) + 32'(q.ack_seq) + 32'(num);
         end
         push(q);
      end
   endtask

   task automatic send_tick();
      push(blank(CMD_TICK));
   endtask

   // Ack number inside the outstanding range, or base when nothing is out
   function automatic logic [15:0] pick_ack();
      bit [15:0] span;
      span = sb.nts - sb.base;
      if (span == 0) return sb.base;
      return sb.base + 16'($urandom_range(0, span - 1));
   endfunction

   // Drain outstanding responses, let the block settle, then write a register
   task automatic write_csr(logic idx, logic [15:0] data);
      req_ch.valid <= 0;
      burst_left = 0;
      @(posedge clock);
      wait (sb.expected.size() == 0);
      repeat (30) @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.write_reg(idx, data);
   endtask

   task automatic random_item();
      int pick;
      req_word_type q;
      pick = $urandom_range(0, 99);
      if (pick < 50) send_msg(($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : NWORD,
                              1, 0);
      else if (pick < 70) send_ack($urandom_range(1, NWORD), pick_ack(), 1);
      else if (pick < 85) send_tick();
      else if (pick < 90) send_ack($urandom_range(1, 2), 16'($urandom),
                                   1'($urandom_range(0, 1)));
      else if (pick < 95) begin
         // broken sequence: a lone partial word of either kind
         q = blank($urandom_range(0, 1) ? CMD_ACK : CMD_MSG);
         q.word_last = 0;
         push(q);
      end else push(blank(CMD_IDLE));
   endtask

   initial begin : stimulus
      logic [3:0]  win_set [5] = '{4'd1, 4'd15, 4'd0, 4'd4, 4'd8};
      logic [15:0] tmo_set [5] = '{16'd1, 16'd3, 16'd0, 16'd65535, 16'd2};
      req_word_type q;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset settings (window 8, timeout 25)
      send_tick();                        // timer not running yet
      send_msg(NWORD, 0, 32'hFFFF_FFFF);  // all-ones payload, seq 1
      send_msg(1, 0, 32'h0);              // short message, zero-filled
      send_ack(2, 16'd1, 1);              // valid ack for seq 1
      send_ack(1, 16'd2, 0);              // wrong checksum
      send_ack(1, 16'd9, 1);              // ack of unsent seq
      q = blank(CMD_MSG); q.word_last = 0;
      push(q); push(q);                   // partial message...
      send_ack(1, 16'd2, 1);              // ...discarded by an ack
      push(blank(CMD_IDLE));
      send_msg(3, 1, 0);
      q = blank(CMD_MSG); q.word_last = 0;
      push(q);
      send_tick();                        // tick leaves partial message alone
      q.word_last = 1; push(q);
      for (int i = 0; i < 3; i++) send_tick();

      // random phases across register settings
      for (int p = 0; p < 5; p++) begin
         write_csr(REG_WINDOW, 16'(win_set[p]));
         write_csr(REG_TIMEOUT, tmo_set[p]);
         for (int i = 0; i < 9; i++) random_item();
      end

      req_ch.valid <= 0;
      wait (sb.expected.size() == 0);
      repeat (60) @(posedge clock);
      if (sb.errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

/* files.f */
hdl/gbn_pkg.sv
hdl/gbn_if.sv
hdl/gbn_datapath.sv
hdl/gbn_controller.sv
hdl/go_back_n_sender_unit.sv
sim/go_back_n_sender_unit_test.sv
